// ===== hdl/jet_false_color_map_defines.svh =====
// Assertion macros shared by the jet color map checker
`ifndef JET_FALSE_COLOR_MAP_DEFINES_SVH
`define JET_FALSE_COLOR_MAP_DEFINES_SVH

// Check a property on every clock edge outside reset
`define JFCM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define JFCM_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/jfcm_pkg.sv =====
// Types, constants and color stop table for the jet color map
`default_nettype none
package jfcm_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int POSITION_BITS   = 16;
	localparam int SEG_BITS        = 3;
	localparam int FRAC_BITS       = POSITION_BITS - SEG_BITS;
	localparam int CHAN_BITS       = 8;
	localparam int NUM_CHAN        = 3;
	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES      = (POSITION_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int LATENCY         = DIV_STAGES + 3;
	localparam int PROD_BITS       = CHAN_BITS + FRAC_BITS + 2;

	localparam logic [SAMPLE_BITS-1:0] RANGE_LOW_RST  = SAMPLE_BITS'(0);
	localparam logic [SAMPLE_BITS-1:0] RANGE_HIGH_RST = SAMPLE_BITS'(65535);

	localparam logic REG_RANGE_LOW  = 1'b0;
	localparam logic REG_RANGE_HIGH = 1'b1;

	localparam logic [SEG_BITS:0] LAST_STOP = (SEG_BITS + 1)'(8);

	typedef struct packed {
		logic                     vld;
		logic                     sat;
		logic [SAMPLE_BITS-1:0]   rem;
		logic [POSITION_BITS-1:0] quo;
	} jfcm_div_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] r;
		logic [CHAN_BITS-1:0] g;
		logic [CHAN_BITS-1:0] b;
	} jfcm_rgb_t;

	function automatic jfcm_rgb_t jfcm_stop(input logic [SEG_BITS:0] idx);
		jfcm_rgb_t c;
		unique case (idx)
			4'd0:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd127};
			4'd1:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
			4'd2:    c = '{r: 8'd0,   g: 8'd127, b: 8'd255};
			4'd3:    c = '{r: 8'd0,   g: 8'd255, b: 8'd255};
			4'd4:    c = '{r: 8'd127, g: 8'd255, b: 8'd127};
			4'd5:    c = '{r: 8'd255, g: 8'd255, b: 8'd0};
			4'd6:    c = '{r: 8'd255, g: 8'd127, b: 8'd0};
			4'd7:    c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
			default: c = '{r: 8'd127, g: 8'd0,   b: 8'd0};
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/jfcm_divider.sv =====
// Pipelined restoring divider producing the normalized position
`default_nettype none
module jfcm_divider (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire jfcm_pkg::jfcm_div_t            head,
	input  wire logic [jfcm_pkg::SAMPLE_BITS-1:0] span,
	output jfcm_pkg::jfcm_div_t                 tail
);

	jfcm_pkg::jfcm_div_t div_s [jfcm_pkg::DIV_STAGES+1];
	jfcm_pkg::jfcm_div_t div_nxt [jfcm_pkg::DIV_STAGES];
	logic                vld_s [jfcm_pkg::DIV_STAGES+1];

	always_comb begin
		div_s[0] = head;
		vld_s[0] = head.vld;
	end

	for (genvar j = 0; j < jfcm_pkg::DIV_STAGES; j++) begin : g_stage
		always_comb begin
			logic [jfcm_pkg::SAMPLE_BITS:0] trial;
			logic                           bit_q;
			div_nxt[j] = div_s[j];
			for (int t = 0; t < jfcm_pkg::STEPS_PER_STAGE; t++) begin
				if (j * jfcm_pkg::STEPS_PER_STAGE + t < jfcm_pkg::POSITION_BITS) begin
					trial = {div_nxt[j].rem, 1'b0};
					bit_q = (trial >= {1'b0, span});
					if (bit_q) begin
						trial = trial - {1'b0, span};
					end
					div_nxt[j].rem = trial[jfcm_pkg::SAMPLE_BITS-1:0];
					div_nxt[j].quo = {div_nxt[j].quo[jfcm_pkg::POSITION_BITS-2:0], bit_q};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			div_s[j+1] <= div_nxt[j];
		end
	end

	always_comb begin
		tail     = div_s[jfcm_pkg::DIV_STAGES];
		tail.vld = vld_s[jfcm_pkg::DIV_STAGES];
	end

endmodule
`default_nettype wire

// ===== hdl/jfcm_blend.sv =====
// Segment lookup and linear interpolation of the three color channels
`default_nettype none
module jfcm_blend (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire jfcm_pkg::jfcm_div_t           pos,
	output logic                               done,
	output logic [jfcm_pkg::CHAN_BITS-1:0]     red,
	output logic [jfcm_pkg::CHAN_BITS-1:0]     green,
	output logic [jfcm_pkg::CHAN_BITS-1:0]     blue
);

	logic [jfcm_pkg::SEG_BITS:0]         idx;
	logic [jfcm_pkg::FRAC_BITS-1:0]      frac;
	jfcm_pkg::jfcm_rgb_t                 c_lo;
	jfcm_pkg::jfcm_rgb_t                 c_hi;
	logic [jfcm_pkg::CHAN_BITS-1:0]      base   [jfcm_pkg::NUM_CHAN];
	logic [jfcm_pkg::CHAN_BITS-1:0]      top    [jfcm_pkg::NUM_CHAN];
	logic signed [jfcm_pkg::CHAN_BITS:0] delta  [jfcm_pkg::NUM_CHAN];
	logic signed [jfcm_pkg::PROD_BITS-1:0] prod [jfcm_pkg::NUM_CHAN];

	logic                                  vld_s1;
	logic [jfcm_pkg::CHAN_BITS-1:0]        base_s1 [jfcm_pkg::NUM_CHAN];
	logic signed [jfcm_pkg::PROD_BITS-1:0] prod_s1 [jfcm_pkg::NUM_CHAN];
	logic signed [jfcm_pkg::PROD_BITS-1:0] sum     [jfcm_pkg::NUM_CHAN];
	logic [jfcm_pkg::CHAN_BITS-1:0]        chan_s2 [jfcm_pkg::NUM_CHAN];

	always_comb begin
		idx  = pos.sat ? jfcm_pkg::LAST_STOP
		               : {1'b0, pos.quo[jfcm_pkg::POSITION_BITS-1 -: jfcm_pkg::SEG_BITS]};
		frac = pos.sat ? '0 : pos.quo[jfcm_pkg::FRAC_BITS-1:0];
		c_lo = jfcm_pkg::jfcm_stop(idx);
		c_hi = jfcm_pkg::jfcm_stop((jfcm_pkg::SEG_BITS + 1)'(idx + 1'b1));
		base[0] = c_lo.r;
		base[1] = c_lo.g;
		base[2] = c_lo.b;
		top[0]  = c_hi.r;
		top[1]  = c_hi.g;
		top[2]  = c_hi.b;
		for (int c = 0; c < jfcm_pkg::NUM_CHAN; c++) begin
			delta[c] = $signed({1'b0, top[c]}) - $signed({1'b0, base[c]});
			prod[c]  = jfcm_pkg::PROD_BITS'(delta[c])
			         * $signed(jfcm_pkg::PROD_BITS'({1'b0, frac}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= pos.vld;
			done   <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < jfcm_pkg::NUM_CHAN; c++) begin
			base_s1[c] <= base[c];
			prod_s1[c] <= prod[c];
		end
	end

	always_comb begin
		for (int c = 0; c < jfcm_pkg::NUM_CHAN; c++) begin
			sum[c] = $signed({2'b00, base_s1[c], {jfcm_pkg::FRAC_BITS{1'b0}}}) + prod_s1[c];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < jfcm_pkg::NUM_CHAN; c++) begin
			chan_s2[c] <= sum[c][jfcm_pkg::FRAC_BITS +: jfcm_pkg::CHAN_BITS];
		end
	end

	assign red   = chan_s2[0];
	assign green = chan_s2[1];
	assign blue  = chan_s2[2];

endmodule
`default_nettype wire

// ===== hdl/jet_false_color_map.sv =====
// Jet false color map: clamp, pipelined divide, segment interpolation
// Throughput: one request per clock; busy stays low.
// A request passes through the clamp stage, four divider stages of four quotient bits,
// and the multiply and sum registers before it drives done.
// Reset clears all valid bits and loads range_low = 0, range_high = 65535.
// A range write applies to requests taken after the edge that writes it.
`default_nettype none
module jet_false_color_map (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [jfcm_pkg::SAMPLE_BITS-1:0]  sample,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic                              cfg_index,
	input  wire logic [jfcm_pkg::SAMPLE_BITS-1:0]  cfg_data,
	output logic                                   done,
	output logic [jfcm_pkg::CHAN_BITS-1:0]         red,
	output logic [jfcm_pkg::CHAN_BITS-1:0]         green,
	output logic [jfcm_pkg::CHAN_BITS-1:0]         blue
);

	logic [jfcm_pkg::SAMPLE_BITS-1:0] range_low_q;
	logic [jfcm_pkg::SAMPLE_BITS-1:0] range_high_q;
	logic [jfcm_pkg::SAMPLE_BITS-1:0] span_q;
	logic                             accept;
	logic                             below;
	logic                             at_top;
	logic                             empty;
	logic                             vld_s1;
	logic                             sat_s1;
	logic [jfcm_pkg::SAMPLE_BITS-1:0] num_s1;
	jfcm_pkg::jfcm_div_t              head;
	jfcm_pkg::jfcm_div_t              tail;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= jfcm_pkg::RANGE_LOW_RST;
			range_high_q <= jfcm_pkg::RANGE_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				jfcm_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_data;
				jfcm_pkg::REG_RANGE_HIGH: range_high_q <= cfg_data;
				default:                  range_low_q  <= range_low_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		span_q <= range_high_q - range_low_q;
	end

	always_comb begin
		below  = sample < range_low_q;
		at_top = sample >= range_high_q;
		empty  = range_high_q <= range_low_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		sat_s1 <= empty || at_top;
		num_s1 <= below ? '0 : sample - range_low_q;
	end

	always_comb begin
		head.vld = vld_s1;
		head.sat = sat_s1;
		head.rem = num_s1;
		head.quo = '0;
	end

	jfcm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.span   (span_q),
		.tail   (tail)
	);

	jfcm_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.pos    (tail),
		.done   (done),
		.red    (red),
		.green  (green),
		.blue   (blue)
	);

endmodule
`default_nettype wire

// ===== hdl/jfcm_checker.sv =====
// Port-level checker for the jet color map and its bind statement
`default_nettype none
`include "jet_false_color_map_defines.svh"
module jfcm_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          done,
	input wire logic [jfcm_pkg::CHAN_BITS-1:0] red,
	input wire logic [jfcm_pkg::CHAN_BITS-1:0] green,
	input wire logic [jfcm_pkg::CHAN_BITS-1:0] blue
);

	`JFCM_ASSERT_NEVER(a_never_busy, busy, "busy raised on a stream block")
	`JFCM_ASSERT(a_done_has_request, done |-> $past(start && !busy, jfcm_pkg::LATENCY), "done without matching request")
	`JFCM_ASSERT(a_jet_hue, (done && red != '0 && blue != '0) |-> (green == '1), "red and blue mixed off the green band")

endmodule

bind jet_false_color_map jfcm_checker u_chk (.*);
`default_nettype wire
